// ----- hdl/vhprs_pkg.sv -----
// shared constants and codes for the vacuum head pick and release sequencer
package vhprs_pkg;

  // head count and retry limit
  localparam int HEADS        = 6;
  localparam int MAX_ATTEMPTS = 2;

  // field widths
  localparam int MODE_W    = 2;
  localparam int HEAD_W    = 3;
  localparam int ACT_W     = 3;
  localparam int STATUS_W  = 2;
  localparam int PHASE_W   = 3;
  localparam int RETRY_W   = 2;
  localparam int DELAY_W   = 16;
  localparam int TIMER_W   = 17;
  localparam int PROD_W    = DELAY_W + RETRY_W + 1;

  // configuration port
  localparam int PADDR_W   = 5;
  localparam int PDATA_W   = 32;
  localparam int REG_IDX_W = 3;

  localparam logic [TIMER_W-1:0] TIMER_MAX = '1;

  // register indexes
  localparam logic [REG_IDX_W-1:0] REG_DOWN_DELAY        = 3'd0;
  localparam logic [REG_IDX_W-1:0] REG_UP_DELAY          = 3'd1;
  localparam logic [REG_IDX_W-1:0] REG_SWITCH_DELAY      = 3'd2;
  localparam logic [REG_IDX_W-1:0] REG_PICK_AIR_DELAY    = 3'd3;
  localparam logic [REG_IDX_W-1:0] REG_RELEASE_AIR_DELAY = 3'd4;

  // register reset values
  localparam logic [DELAY_W-1:0] RST_DOWN_DELAY        = 16'd500;
  localparam logic [DELAY_W-1:0] RST_UP_DELAY          = 16'd500;
  localparam logic [DELAY_W-1:0] RST_SWITCH_DELAY      = 16'd100;
  localparam logic [DELAY_W-1:0] RST_PICK_AIR_DELAY    = 16'd200;
  localparam logic [DELAY_W-1:0] RST_RELEASE_AIR_DELAY = 16'd200;

  // input modes
  localparam logic [MODE_W-1:0] MODE_START_PICK    = 2'd0;
  localparam logic [MODE_W-1:0] MODE_START_RELEASE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_STEP_PICK     = 2'd2;
  localparam logic [MODE_W-1:0] MODE_STEP_RELEASE  = 2'd3;

  // valve actions
  localparam logic [ACT_W-1:0] ACT_NONE     = 3'd0;
  localparam logic [ACT_W-1:0] ACT_CYL_DOWN = 3'd1;
  localparam logic [ACT_W-1:0] ACT_CYL_UP   = 3'd2;
  localparam logic [ACT_W-1:0] ACT_VAC_OFF  = 3'd3;
  localparam logic [ACT_W-1:0] ACT_VAC_ON   = 3'd4;

  // job status
  localparam logic [STATUS_W-1:0] ST_NEVER   = 2'd0;
  localparam logic [STATUS_W-1:0] ST_RUNNING = 2'd1;
  localparam logic [STATUS_W-1:0] ST_OK      = 2'd2;
  localparam logic [STATUS_W-1:0] ST_FAILED  = 2'd3;

  // sequence phases
  localparam logic [PHASE_W-1:0] PH_IDLE      = 3'd0;
  localparam logic [PHASE_W-1:0] PH_DOWN      = 3'd1;
  localparam logic [PHASE_W-1:0] PH_VAC_OFF   = 3'd2;
  localparam logic [PHASE_W-1:0] PH_VAC_ON    = 3'd3;
  localparam logic [PHASE_W-1:0] PH_UP        = 3'd4;
  localparam logic [PHASE_W-1:0] PH_CHECK     = 3'd5;
  localparam logic [PHASE_W-1:0] PH_DONE_OK   = 3'd6;
  localparam logic [PHASE_W-1:0] PH_DONE_FAIL = 3'd7;

endpackage

// ----- hdl/vacuum_head_pick_release_sequencer.sv -----
// top level of the six-head vacuum pick and release sequencer
//
// Each head keeps two jobs, pick and release. A request word names a head
// and a mode: start pick, start release, step pick or step release. A start
// arms the job at cylinder down; every step moves the job one phase along
// (down, vacuum off, vacuum on or wait, up, check, done) once its delay
// timer has run out, and counts that timer down by one. The check reads
// part_held; a failed check retries with down and up delays scaled by the
// attempt number, and the job fails after two attempts. Heads above five
// return a word with accepted low and nothing changed.
// Request channel: req_valid / req_stall, response channel: rsp_valid /
// rsp_stall. Delays are set over the APB-style port at any idle time.
// A request word is held in an input register, processed against the head
// state and written to the response register; one word is taken every
// cycle unless req_stall is high. While the response is
// stalled, one more request is taken into the input register and then
// req_stall rises. Reset clears every job to idle, never started, timer
// zero, and loads the default delays.
module vacuum_head_pick_release_sequencer
  import vhprs_pkg::*;
(
  input  logic                clk,
  input  logic                rst,
  // request channel
  input  logic                req_valid,
  output logic                req_stall,
  input  logic [MODE_W-1:0]   mode,
  input  logic [HEAD_W-1:0]   head,
  input  logic                part_held,
  // response channel
  output logic                rsp_valid,
  input  logic                rsp_stall,
  output logic [HEAD_W-1:0]   head_out,
  output logic                accepted,
  output logic [ACT_W-1:0]    action,
  output logic [STATUS_W-1:0] job_status,
  output logic [PHASE_W-1:0]  phase,
  output logic [RETRY_W-1:0]  attempts,
  // configuration port
  input  logic                psel,
  input  logic                penable,
  input  logic                pwrite,
  input  logic [PADDR_W-1:0]  paddr,
  input  logic [PDATA_W-1:0]  pwdata,
  output logic [PDATA_W-1:0]  prdata,
  output logic                pready
);

  // configuration registers
  logic [DELAY_W-1:0] down_delay, up_delay, switch_delay;
  logic [DELAY_W-1:0] pick_air_delay, release_air_delay;

  // per head job state
  logic [PHASE_W-1:0]  pick_phase     [HEADS];
  logic [RETRY_W-1:0]  pick_retry     [HEADS];
  logic [TIMER_W-1:0]  pick_timer     [HEADS];
  logic [STATUS_W-1:0] pick_status    [HEADS];
  logic [PHASE_W-1:0]  release_phase  [HEADS];
  logic [RETRY_W-1:0]  release_retry  [HEADS];
  logic [TIMER_W-1:0]  release_timer  [HEADS];
  logic [STATUS_W-1:0] release_status [HEADS];

  // input register
  logic               s_valid;
  logic [MODE_W-1:0]  s_mode;
  logic [HEAD_W-1:0]  s_head;
  logic               s_held;

  // stage control
  logic res_load, s_fire, req_fire, cfg_write;
  logic [REG_IDX_W-1:0] reg_idx;

  // process stage signals
  logic                sel_pick, is_start, head_ok, ready, check_ok;
  logic [PHASE_W-1:0]  cur_phase, phase_next;
  logic [RETRY_W-1:0]  cur_retry, retry_next, retry_inc;
  logic [TIMER_W-1:0]  cur_timer, timer_next;
  logic [STATUS_W-1:0] cur_status, status_next;
  logic [ACT_W-1:0]    act;

  // delay scaled by the attempt number, saturated to the timer width
  function automatic logic [TIMER_W-1:0] scaled_delay(input logic [DELAY_W-1:0] base,
                                                      input logic [RETRY_W-1:0] retry);
    logic [PROD_W-1:0] prod;
    prod = PROD_W'(base) * PROD_W'({1'b0, retry} + 3'd1);
    return (prod > PROD_W'(TIMER_MAX)) ? TIMER_MAX : prod[TIMER_W-1:0];
  endfunction

  // handshake
  assign res_load  = !rsp_valid || !rsp_stall;
  assign s_fire    = s_valid && res_load;
  assign req_stall = s_valid && !res_load;
  assign req_fire  = req_valid && !req_stall;

  // configuration access
  assign pready    = 1'b1;
  assign reg_idx   = paddr[PADDR_W-1:2];
  assign cfg_write = psel && penable && pwrite && pready;

  always_comb begin
    prdata = '0;
    unique case (reg_idx)
      REG_DOWN_DELAY:        prdata = PDATA_W'(down_delay);
      REG_UP_DELAY:          prdata = PDATA_W'(up_delay);
      REG_SWITCH_DELAY:      prdata = PDATA_W'(switch_delay);
      REG_PICK_AIR_DELAY:    prdata = PDATA_W'(pick_air_delay);
      REG_RELEASE_AIR_DELAY: prdata = PDATA_W'(release_air_delay);
      default:               prdata = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      down_delay        <= RST_DOWN_DELAY;
      up_delay          <= RST_UP_DELAY;
      switch_delay      <= RST_SWITCH_DELAY;
      pick_air_delay    <= RST_PICK_AIR_DELAY;
      release_air_delay <= RST_RELEASE_AIR_DELAY;
    end else if (cfg_write) begin
      unique case (reg_idx)
        REG_DOWN_DELAY:        down_delay        <= pwdata[DELAY_W-1:0];
        REG_UP_DELAY:          up_delay          <= pwdata[DELAY_W-1:0];
        REG_SWITCH_DELAY:      switch_delay      <= pwdata[DELAY_W-1:0];
        REG_PICK_AIR_DELAY:    pick_air_delay    <= pwdata[DELAY_W-1:0];
        REG_RELEASE_AIR_DELAY: release_air_delay <= pwdata[DELAY_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s_valid <= 1'b0;
    end else if (req_fire) begin
      s_valid <= 1'b1;
    end else if (s_fire) begin
      s_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      s_mode <= mode;
      s_head <= head;
      s_held <= part_held;
    end
  end

  // read the addressed job
  assign sel_pick = (s_mode == MODE_START_PICK) || (s_mode == MODE_STEP_PICK);
  assign is_start = (s_mode == MODE_START_PICK) || (s_mode == MODE_START_RELEASE);
  assign head_ok  = {1'b0, s_head} < (HEAD_W + 1)'(HEADS);

  always_comb begin
    cur_phase  = PH_IDLE;
    cur_retry  = '0;
    cur_timer  = '0;
    cur_status = ST_NEVER;
    if (head_ok) begin
      cur_phase  = sel_pick ? pick_phase[s_head]  : release_phase[s_head];
      cur_retry  = sel_pick ? pick_retry[s_head]  : release_retry[s_head];
      cur_timer  = sel_pick ? pick_timer[s_head]  : release_timer[s_head];
      cur_status = sel_pick ? pick_status[s_head] : release_status[s_head];
    end
  end

  // phase step of one job
  assign ready     = (cur_timer == '0);
  assign check_ok  = sel_pick ? s_held : !s_held;
  assign retry_inc = (cur_retry == '1) ? cur_retry : cur_retry + 1'b1;

  always_comb begin
    phase_next  = cur_phase;
    retry_next  = cur_retry;
    timer_next  = cur_timer;
    status_next = cur_status;
    act         = ACT_NONE;
    if (is_start) begin
      phase_next  = PH_DOWN;
      retry_next  = '0;
      timer_next  = '0;
      status_next = ST_RUNNING;
    end else begin
      unique case (cur_phase)
        PH_IDLE: begin
          retry_next = '0;
        end
        PH_DOWN: begin
          act        = ACT_CYL_DOWN;
          timer_next = scaled_delay(down_delay, cur_retry);
          phase_next = PH_VAC_OFF;
        end
        PH_VAC_OFF: begin
          if (ready) begin
            act        = ACT_VAC_OFF;
            timer_next = TIMER_W'(switch_delay);
            phase_next = PH_VAC_ON;
          end
        end
        PH_VAC_ON: begin
          if (ready) begin
            act        = sel_pick ? ACT_VAC_ON : ACT_NONE;
            timer_next = sel_pick ? TIMER_W'(pick_air_delay) : TIMER_W'(release_air_delay);
            phase_next = PH_UP;
          end
        end
        PH_UP: begin
          if (ready) begin
            act        = ACT_CYL_UP;
            timer_next = scaled_delay(up_delay, cur_retry);
            phase_next = PH_CHECK;
          end
        end
        PH_CHECK: begin
          if (ready) begin
            if (check_ok) begin
              phase_next = PH_DONE_OK;
            end else begin
              retry_next = retry_inc;
              phase_next = (32'(retry_inc) < MAX_ATTEMPTS) ? PH_DOWN : PH_DONE_FAIL;
            end
          end
        end
        PH_DONE_OK: begin
          status_next = ST_OK;
          phase_next  = PH_IDLE;
        end
        PH_DONE_FAIL: begin
          status_next = ST_FAILED;
          phase_next  = PH_IDLE;
        end
        default: ;
      endcase
      // timer counts down at the end of every step
      if (timer_next != '0) begin
        timer_next = timer_next - 1'b1;
      end
    end
  end

  // job state write back
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < HEADS; i++) begin
        pick_phase[i]     <= PH_IDLE;
        pick_retry[i]     <= '0;
        pick_timer[i]     <= '0;
        pick_status[i]    <= ST_NEVER;
        release_phase[i]  <= PH_IDLE;
        release_retry[i]  <= '0;
        release_timer[i]  <= '0;
        release_status[i] <= ST_NEVER;
      end
    end else if (s_fire && head_ok) begin
      if (sel_pick) begin
        pick_phase[s_head]  <= phase_next;
        pick_retry[s_head]  <= retry_next;
        pick_timer[s_head]  <= timer_next;
        pick_status[s_head] <= status_next;
      end else begin
        release_phase[s_head]  <= phase_next;
        release_retry[s_head]  <= retry_next;
        release_timer[s_head]  <= timer_next;
        release_status[s_head] <= status_next;
      end
    end
  end

  // response register
  always_ff @(posedge clk) begin
    if (rst) begin
      rsp_valid <= 1'b0;
    end else if (res_load) begin
      rsp_valid <= s_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_fire) begin
      head_out   <= s_head;
      accepted   <= head_ok;
      action     <= head_ok ? act         : ACT_NONE;
      job_status <= head_ok ? status_next : ST_NEVER;
      phase      <= head_ok ? phase_next  : PH_IDLE;
      attempts   <= head_ok ? retry_next  : '0;
    end
  end

  // checks
  a_accept_head: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (accepted == ({1'b0, head_out} < (HEAD_W + 1)'(HEADS))))
    else $error("accepted flag does not match head range");

  a_attempt_limit: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> (32'(attempts) <= MAX_ATTEMPTS))
    else $error("attempt count above limit");

  a_vac_on_phase: assert property (@(posedge clk) disable iff (rst)
    (rsp_valid && (action == ACT_VAC_ON)) |-> (phase == PH_UP))
    else $error("vacuum on outside pick air phase");

  a_full_stall: assert property (@(posedge clk) disable iff (rst)
    (s_valid && rsp_valid && rsp_stall) |-> req_stall)
    else $error("request taken with both stages full");

endmodule
